FILE: sv/idp_pkg.sv
package idp_pkg;

    // Characters of the duration grammar
    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_P   = 8'h50;
    localparam logic [7:0] CH_T   = 8'h54;
    localparam logic [7:0] CH_Y   = 8'h59;
    localparam logic [7:0] CH_M   = 8'h4D;
    localparam logic [7:0] CH_W   = 8'h57;
    localparam logic [7:0] CH_D   = 8'h44;
    localparam logic [7:0] CH_H   = 8'h48;
    localparam logic [7:0] CH_S   = 8'h53;
    localparam logic [7:0] CH_0   = 8'h30;
    localparam logic [7:0] CH_9   = 8'h39;

    // Result layout: ok flag, then seven 32-bit fields, padded to whole bytes
    localparam int NUM_FIELDS  = 7;
    localparam int FIELD_W     = 32;
    localparam int RESULT_BITS = 1 + NUM_FIELDS * FIELD_W;
    localparam int OUT_TDATA_W = ((RESULT_BITS + 7) / 8) * 8;

    typedef enum logic [1:0] {
        PH_EXPECT_P,
        PH_FIRST,
        PH_BODY
    } phase_t;

    typedef struct packed {
        phase_t phase;
        logic   in_time;
        logic   failed;
        logic   pending;
    } ctrl_t;

    localparam ctrl_t CTRL_IDLE = '{phase: PH_EXPECT_P, in_time: 1'b0,
                                    failed: 1'b0, pending: 1'b0};

    // Field to store into; SEL_YEAR .. SEL_SECOND map to field index 0 .. 6
    typedef enum logic [2:0] {
        SEL_NONE,
        SEL_YEAR,
        SEL_MONTH,
        SEL_WEEK,
        SEL_DAY,
        SEL_HOUR,
        SEL_MINUTE,
        SEL_SECOND
    } sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_DIGIT,
        ACC_CLEAR
    } acc_op_t;

    typedef struct packed {
        ctrl_t   ctrl_next;
        acc_op_t acc_op;
        sel_t    sel;
        logic    emit;
        logic    ok;
    } step_t;

endpackage

FILE: sv/idp_decode.sv
module idp_decode
    import idp_pkg::*;
(
    input  logic [7:0] ch,
    input  ctrl_t      ctrl,
    output step_t      step
);

    // Classify one byte against the current parse state
    always_comb
    begin
        step.ctrl_next = ctrl;
        step.acc_op    = ACC_HOLD;
        step.sel       = SEL_NONE;
        step.emit      = 1'b0;
        step.ok        = (ctrl.phase == PH_BODY) && !ctrl.failed && !ctrl.pending;

        priority if (ch == CH_NUL)
        begin
            // terminator: report and return to idle
            step.emit      = 1'b1;
            step.ctrl_next = CTRL_IDLE;
            step.acc_op    = ACC_CLEAR;
        end
        else if (ctrl.failed)
        begin
            // drop bytes until the terminator
        end
        else if (ctrl.phase == PH_EXPECT_P)
        begin
            if (ch == CH_P)
                step.ctrl_next.phase = PH_FIRST;
            else
                step.ctrl_next.failed = 1'b1;
        end
        else if (ch >= CH_0 && ch <= CH_9)
        begin
            step.ctrl_next.phase   = PH_BODY;
            step.ctrl_next.pending = 1'b1;
            step.acc_op            = ACC_DIGIT;
        end
        else
        begin
            step.ctrl_next.phase = PH_BODY;
            unique case (ch)
                CH_Y: step.sel = SEL_YEAR;
                CH_M: step.sel = ctrl.in_time ? SEL_MINUTE : SEL_MONTH;
                CH_W: step.sel = SEL_WEEK;
                CH_D: step.sel = SEL_DAY;
                CH_H: step.sel = SEL_HOUR;
                CH_S: step.sel = SEL_SECOND;
                CH_T:
                begin
                    if (ctrl.in_time)
                        step.ctrl_next.failed = 1'b1;
                    else
                    begin
                        step.ctrl_next.in_time = 1'b1;
                        step.ctrl_next.pending = 1'b0;
                        step.acc_op            = ACC_CLEAR;
                    end
                end
                default: step.ctrl_next.failed = 1'b1;
            endcase
            // a designator stores the accumulator and clears it
            if (step.sel != SEL_NONE)
            begin
                step.ctrl_next.pending = 1'b0;
                step.acc_op            = ACC_CLEAR;
            end
        end
    end

endmodule

FILE: sv/iso8601_duration_parser.sv
// ISO 8601 duration parser (P[nY][nM][nW][nD][T[nH][nM][nS]]).
// Input stream s_*: one character byte per transfer in s_tdata; a zero byte
// ends the string. Output stream m_*: one result per zero byte, carrying the
// ok flag and the seven fields years .. seconds (32 bits each).
// Latency: the result is valid in the cycle after the zero byte's transfer.
// Throughput: one byte per cycle while no waiting result stalls the input; each
// byte is decoded by single-level logic between the parse-state registers and
// the result register, the accumulator update being a shift-add by ten and one add.
// The result register decouples the sides: while a result waits, s_tready
// follows m_tready, so a stalled receiver stalls the input, and bytes flow as
// soon as the result is taken (same cycle).
// Reset (rst_n low, asynchronous) returns to waiting for the leading P with
// all fields and the accumulator zero and no result pending. Every result also
// returns the parse state to this idle condition.
// VALUE_WIDTH sets the accumulator and field storage width; results carry the
// low 32 bits, zero-extended when VALUE_WIDTH is narrower.
module iso8601_duration_parser
    import idp_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // [7:0] ch
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata    // [0] ok, [32:1] years, [64:33] months,
                                              // [96:65] weeks, [128:97] days,
                                              // [160:129] hours, [192:161] minutes,
                                              // [224:193] seconds, rest zero
);

    ctrl_t                   ctrl_reg;
    logic [VALUE_WIDTH-1:0]  acc_reg;
    logic [VALUE_WIDTH-1:0]  acc_next;
    logic [VALUE_WIDTH-1:0]  field_reg [NUM_FIELDS];
    logic [FIELD_W-1:0]      field_out [NUM_FIELDS];
    logic                    m_tvalid_reg;
    logic [OUT_TDATA_W-1:0]  m_tdata_reg;
    logic [OUT_TDATA_W-1:0]  m_tdata_next;
    logic [7:0]              digit_full;
    logic                    accept;
    step_t                   step;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    idp_decode u_decode (
        .ch   (s_tdata),
        .ctrl (ctrl_reg),
        .step (step)
    );

    // Accumulator: acc * 10 + digit, wrapping at VALUE_WIDTH
    assign digit_full = s_tdata - CH_0;
    always_comb
    begin
        unique case (step.acc_op)
            ACC_DIGIT: acc_next = (acc_reg << 3) + (acc_reg << 1)
                                  + {{(VALUE_WIDTH-4){1'b0}}, digit_full[3:0]};
            ACC_CLEAR: acc_next = '0;
            default:   acc_next = acc_reg;
        endcase
    end

    // Hold parse state and accumulator
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= CTRL_IDLE;
            acc_reg  <= '0;
        end
        else if (accept)
        begin
            ctrl_reg <= step.ctrl_next;
            acc_reg  <= acc_next;
        end
    end

    // Field storage: load on designator, clear on terminator
    for (genvar k = 0; k < NUM_FIELDS; k++)
    begin : g_field
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                field_reg[k] <= '0;
            else if (accept && step.emit)
                field_reg[k] <= '0;
            else if (accept && step.sel == sel_t'(3'(k + 1)))
                field_reg[k] <= acc_reg;
        end

        if (VALUE_WIDTH >= FIELD_W)
        begin : g_trunc
            assign field_out[k] = field_reg[k][FIELD_W-1:0];
        end
        else
        begin : g_ext
            assign field_out[k] = {{(FIELD_W-VALUE_WIDTH){1'b0}}, field_reg[k]};
        end
    end

    // Pack the result word
    always_comb
    begin
        m_tdata_next    = '0;
        m_tdata_next[0] = step.ok;
        for (int k = 0; k < NUM_FIELDS; k++)
            m_tdata_next[1 + k*FIELD_W +: FIELD_W] = field_out[k];
    end

    // Result register: load on terminator, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (accept && step.emit)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept && step.emit)
            m_tdata_reg <= m_tdata_next;
    end

    // A new result only follows a terminator transfer
    a_result_from_nul: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(accept && s_tdata == CH_NUL))
        else $error("result raised without a terminator transfer");

    // Terminator returns the parser to idle
    a_clear_after_nul: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tdata == CH_NUL) |=> (ctrl_reg == CTRL_IDLE && acc_reg == '0))
        else $error("parse state not cleared after terminator");

    // Before the leading P nothing can have accumulated
    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl_reg.phase == PH_EXPECT_P) |->
            (acc_reg == '0 && !ctrl_reg.pending && !ctrl_reg.in_time))
        else $error("state set before leading P");

    // Pending digits only occur in the body
    a_pending_in_body: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_reg.pending |-> ctrl_reg.phase == PH_BODY)
        else $error("pending digits outside the body");

endmodule

FILE: test/iso8601_duration_parser_tb.sv
module iso8601_duration_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import idp_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;

    // Position of each value in the result, years first
    typedef enum int {
        FLD_YEARS,
        FLD_MONTHS,
        FLD_WEEKS,
        FLD_DAYS,
        FLD_HOURS,
        FLD_MINUTES,
        FLD_SECONDS
    } field_idx_t;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    // Parse state tracked alongside the block
    phase_t                 dur_phase;
    logic                   dur_in_time;
    logic                   dur_failed;
    logic                   dur_pending;
    logic [FIELD_W-1:0]     dur_acc;
    logic [FIELD_W-1:0]     dur_field [NUM_FIELDS];

    logic [OUT_TDATA_W-1:0] pending_durations [$];
    logic [7:0]             text [$];

    string field_names [NUM_FIELDS] = '{"years", "months", "weeks", "days",
                                        "hours", "minutes", "seconds"};

    int mismatches   = 0;
    int bytes_sent   = 0;
    int sink_wait    = 0;
    int quiet_cycles = 0;
    bit src_idle     = 1'b0;
    bit sink_idle    = 1'b0;

    iso8601_duration_parser i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Return the tracked parser to its idle condition
    function automatic void clear_parse_state();
        dur_phase   = PH_EXPECT_P;
        dur_in_time = 1'b0;
        dur_failed  = 1'b0;
        dur_pending = 1'b0;
        dur_acc     = '0;
        for (int i = 0; i < NUM_FIELDS; i++)
        begin
            dur_field[i] = '0;
        end
    endfunction

    function automatic void store_field(field_idx_t f);
        dur_field[f] = dur_acc;
        dur_acc      = '0;
        dur_pending  = 1'b0;
    endfunction

    // Advance the tracked parser by one accepted byte; a zero byte queues a result
    function automatic void parse_char(input logic [7:0] c);
        logic [OUT_TDATA_W-1:0] res;
        res = '0;
        if (c == CH_NUL)
        begin
            res[0] = (dur_phase == PH_BODY) && !dur_failed && !dur_pending;
            for (int i = 0; i < NUM_FIELDS; i++)
            begin
                res[1 + FIELD_W * i +: FIELD_W] = dur_field[i];
            end
            pending_durations.push_back(res);
            clear_parse_state();
        end
        else if (!dur_failed)
        begin
            if (dur_phase == PH_EXPECT_P)
            begin
                if (c == CH_P)
                    dur_phase = PH_FIRST;
                else
                    dur_failed = 1'b1;
            end
            else
            begin
                dur_phase = PH_BODY;
                if (c >= CH_0 && c <= CH_9)
                begin
                    dur_acc     = dur_acc * 32'd10 + 32'(c - CH_0);
                    dur_pending = 1'b1;
                end
                else
                begin
                    case (c)
                        CH_Y: store_field(FLD_YEARS);
                        CH_M: store_field(dur_in_time ? FLD_MINUTES : FLD_MONTHS);
                        CH_W: store_field(FLD_WEEKS);
                        CH_D: store_field(FLD_DAYS);
                        CH_H: store_field(FLD_HOURS);
                        CH_S: store_field(FLD_SECONDS);
                        CH_T:
                        begin
                            if (dur_in_time)
                                dur_failed = 1'b1;
                            else
                            begin
                                dur_in_time = 1'b1;
                                dur_acc     = '0;
                                dur_pending = 1'b0;
                            end
                        end
                        default: dur_failed = 1'b1;
                    endcase
                end
            end
        end
    endfunction

    task automatic report_error(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: %s", $time, msg);
    endtask

    // Check each result transfer against the oldest queued duration
    always @(posedge clk)
    begin : check_result
        logic [OUT_TDATA_W-1:0] want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_durations.size() == 0)
                report_error($sformatf("result with no string pending: %h", m_tdata));
            else
            begin
                want = pending_durations.pop_front();
                if (m_tdata[0] !== want[0])
                    report_error($sformatf("ok: expected %0b, got %0b", want[0], m_tdata[0]));
                for (int i = 0; i < NUM_FIELDS; i++)
                begin
                    if (m_tdata[1 + FIELD_W * i +: FIELD_W] !== want[1 + FIELD_W * i +: FIELD_W])
                        report_error($sformatf("%s: expected %0d, got %0d", field_names[i],
                                               want[1 + FIELD_W * i +: FIELD_W],
                                               m_tdata[1 + FIELD_W * i +: FIELD_W]));
                end
                if (m_tdata[OUT_TDATA_W-1:RESULT_BITS] !== '0)
                    report_error($sformatf("padding: expected 0, got %h",
                                           m_tdata[OUT_TDATA_W-1:RESULT_BITS]));
            end
        end
    end

    // Receiver: when sink_idle is set, drop tready for a random stall after each result
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            sink_wait <= 0;
        end
        else if (m_tvalid && m_tready)
        begin
            if (sink_idle)
            begin
                sink_wait <= $urandom_range(0, 6);
                m_tready  <= 1'b0;
            end
        end
        else if (!m_tready)
        begin
            if (sink_wait == 0)
                m_tready <= 1'b1;
            else
                sink_wait <= sink_wait - 1;
        end
    end

    // Count cycles without any transfer on either side
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("FAIL");
        $finish;
    end

    task automatic pick_idle_mode();
        int mode;
        mode      = $urandom_range(0, 3);
        src_idle  = mode[0];
        sink_idle = mode[1];
    endtask

    // Offer one byte, hold it until the transfer, then track it
    task automatic send_char(input logic [7:0] c);
        int gap;
        gap = src_idle ? $urandom_range(0, 6) : 0;
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        parse_char(c);
        bytes_sent++;
    endtask

    task automatic send_text();
        foreach (text[i])
        begin
            send_char(text[i]);
        end
        send_char(CH_NUL);
    endtask

    task automatic load_text(input string s);
        text.delete();
        for (int i = 0; i < s.len(); i++)
        begin
            text.push_back(s[i]);
        end
    endtask

    // Lower tvalid and hold until every queued result has come out
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_durations.size() != 0) @(posedge clk);
    endtask

    // Append a decimal number: often none, sometimes long enough to wrap
    function automatic void append_number();
        int pick;
        int n;
        pick = $urandom_range(0, 9);
        if (pick < 2)
            n = 0;
        else if (pick < 7)
            n = $urandom_range(1, 3);
        else if (pick < 9)
            n = $urandom_range(4, 9);
        else
            n = $urandom_range(10, 14);
        for (int i = 0; i < n; i++)
        begin
            text.push_back(CH_0 + 8'($urandom_range(0, 9)));
        end
    endfunction

    // Build a valid duration with random components in grammar order
    function automatic void build_wellformed();
        logic [7:0] date_des [4];
        logic [7:0] time_des [3];
        date_des = '{CH_Y, CH_M, CH_W, CH_D};
        time_des = '{CH_H, CH_M, CH_S};
        text.delete();
        text.push_back(CH_P);
        foreach (date_des[i])
        begin
            if ($urandom_range(0, 1) == 1)
            begin
                append_number();
                text.push_back(date_des[i]);
                // repeated designator overwrites the earlier value
                if ($urandom_range(0, 7) == 0)
                begin
                    append_number();
                    text.push_back(date_des[i]);
                end
            end
        end
        if ($urandom_range(0, 2) != 0)
        begin
            // digits right before T are discarded
            if ($urandom_range(0, 7) == 0)
                append_number();
            text.push_back(CH_T);
            foreach (time_des[i])
            begin
                if ($urandom_range(0, 1) == 1)
                begin
                    append_number();
                    text.push_back(time_des[i]);
                end
            end
        end
    endfunction

    // Corrupt a valid duration in one of several ways
    function automatic void break_text();
        case ($urandom_range(0, 4))
            0: text.insert($urandom_range(1, text.size()), 8'($urandom_range(1, 255)));
            1: text.push_back(CH_0 + 8'($urandom_range(0, 9)));
            2:
            begin
                text.insert($urandom_range(1, text.size()), CH_T);
                text.insert($urandom_range(1, text.size()), CH_T);
            end
            3: text[0] = 8'($urandom_range(1, 255));
            default: text.insert($urandom_range(1, text.size()), 8'($urandom_range(8'h61, 8'h7a)));
        endcase
    endfunction

    task automatic test_directed_cases();
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        // empty string
        load_text("");
        send_text();
        // bare P
        load_text("P");
        send_text();
        // bad first byte, top of the byte range
        text.delete();
        text.push_back(8'hFF);
        send_text();
        // digits before T are dropped
        load_text("P9T");
        send_text();
        // second T
        load_text("PTT");
        send_text();
        // trailing digits
        load_text("P5");
        send_text();
        // failure after a stored field keeps the field
        load_text("P1Ya2D");
        send_text();
        // designators without digits, month before T and minute after it
        load_text("PMTM");
        send_text();
    endtask

    task automatic test_wellformed_strings(input int n_bytes);
        int stop_at;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at)
        begin
            pick_idle_mode();
            build_wellformed();
            if ($urandom_range(0, 3) == 0)
                break_text();
            send_text();
        end
    endtask

    task automatic test_random_noise(input int n_bytes);
        int stop_at;
        int len;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at)
        begin
            pick_idle_mode();
            text.delete();
            if ($urandom_range(0, 1) == 1)
                text.push_back(CH_P);
            len = $urandom_range(0, 8);
            for (int i = 0; i < len; i++)
            begin
                text.push_back(8'($urandom_range(1, 255)));
            end
            send_text();
        end
    endtask

    // Let the block go fully idle before each string
    task automatic test_after_drain(input int n_strings);
        for (int i = 0; i < n_strings; i++)
        begin
            drain_results();
            pick_idle_mode();
            build_wellformed();
            send_text();
        end
    endtask

    initial
    begin
        clear_parse_state();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_wellformed_strings(750);
        test_random_noise(300);
        test_after_drain(12);

        drain_results();
        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: sim.f
sv/idp_pkg.sv
sv/idp_decode.sv
sv/iso8601_duration_parser.sv
test/iso8601_duration_parser_tb.sv
